// ----- hdl/rpwc_pkg.sv -----
package rpwc_pkg;

    localparam int CHAN_W  = 3;
    localparam int DATA_W  = 16;
    localparam int STAMP_W = 32;

    localparam int CHANNELS_DEF = 5;
    localparam int FRONT_DEPTH  = 2;
    localparam int OUT_DEPTH    = 4;

    localparam logic [DATA_W-1:0] ACCEPT_MIN_RST = 16'd800;
    localparam logic [DATA_W-1:0] ACCEPT_MAX_RST = 16'd2200;
    localparam logic [DATA_W-1:0] VALID_MIN_RST  = 16'd900;
    localparam logic [DATA_W-1:0] VALID_MAX_RST  = 16'd2100;
    localparam logic [DATA_W-1:0] TIMEOUT_RST    = 16'd100;

    typedef enum logic [2:0] {
        CFG_ACCEPT_MIN = 3'd0,
        CFG_ACCEPT_MAX = 3'd1,
        CFG_VALID_MIN  = 3'd2,
        CFG_VALID_MAX  = 3'd3,
        CFG_TIMEOUT    = 3'd4
    } t_cfg_reg;

    // One classified input transaction, as queued between front and back.
    typedef struct packed {
        logic              is_tick;
        logic              in_range;
        logic              rising;
        logic [CHAN_W-1:0] chan;
        logic [DATA_W-1:0] cap;
    } t_op;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [DATA_W-1:0] width_us;
        logic              chan_valid;
        logic              all_valid;
    } t_report;

endpackage

// ----- hdl/rpwc_fifo.sv -----
module rpwc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [WIDTH-1:0]             o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    // DEPTH must be a power of two so that the pointers wrap by themselves; the block does not check it.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             wr;
    logic             rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (rd) begin
                r_rptr <= r_rptr + AW'(1);
            end
            case ({wr, rd})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/rpwc_front.sv -----
module rpwc_front #(
    parameter int CHANNELS = rpwc_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic                        i_req_type,
    input  logic [rpwc_pkg::CHAN_W-1:0] i_channel,
    input  logic                        i_pin_level,
    input  logic [rpwc_pkg::DATA_W-1:0] i_capture_count,
    output logic                        o_op_valid,
    output rpwc_pkg::t_op               o_op,
    input  logic                        i_op_take
);

    rpwc_pkg::t_op op_in;
    logic          empty;

    always_comb begin
        op_in.is_tick  = i_req_type;
        op_in.in_range = ({1'b0, i_channel} < (rpwc_pkg::CHAN_W+1)'(CHANNELS));
        op_in.rising   = i_pin_level;
        op_in.chan     = i_channel;
        op_in.cap      = i_capture_count;
    end

    rpwc_fifo #(
        .WIDTH ($bits(rpwc_pkg::t_op)),
        .DEPTH (rpwc_pkg::FRONT_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (op_in),
        .o_full  (o_full),
        .i_pop   (i_op_take),
        .o_empty (empty),
        .o_data  (o_op),
        .o_count ()
    );

    assign o_op_valid = !empty;

endmodule

// ----- hdl/rpwc_back.sv -----
module rpwc_back #(
    parameter int CHANNELS = rpwc_pkg::CHANNELS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_wr_en,
    input  logic [2:0]                               i_cfg_index,
    input  logic [rpwc_pkg::DATA_W-1:0]              i_cfg_wr_data,
    input  logic                                     i_op_valid,
    input  rpwc_pkg::t_op                            i_op,
    output logic                                     o_op_take,
    input  logic [$clog2(rpwc_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    input  logic                                     i_out_full,
    output logic                                     o_rep_valid,
    output rpwc_pkg::t_report                        o_rep
);

    localparam int CW = $clog2(rpwc_pkg::OUT_DEPTH+1);
    localparam int DW = rpwc_pkg::DATA_W;
    localparam int SW = rpwc_pkg::STAMP_W;
    localparam int NW = rpwc_pkg::CHAN_W;

    logic [DW-1:0] r_accept_min;
    logic [DW-1:0] r_accept_max;
    logic [DW-1:0] r_valid_min;
    logic [DW-1:0] r_valid_max;
    logic [DW-1:0] r_timeout;

    logic [DW-1:0] r_rise  [CHANNELS];
    logic [DW-1:0] r_width [CHANNELS];
    logic [SW-1:0] r_stamp [CHANNELS];
    logic [SW-1:0] r_now;

    logic          r_pend;
    logic [NW-1:0] r_pend_chan;
    logic          r_pend_range;

    logic [DW-1:0]       cur_rise;
    logic [DW-1:0]       n_width;
    logic                n_fits;
    logic [CHANNELS-1:0] ok;
    logic [DW-1:0]       sel_width;
    logic                sel_ok;

    // A transaction is taken only when the result queue has room for it and
    // for the report still in flight.
    assign o_op_take = i_op_valid && ((i_out_count + CW'(r_pend)) < CW'(rpwc_pkg::OUT_DEPTH));

    always_comb begin
        cur_rise = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (i_op.chan == NW'(i)) begin
                cur_rise = r_rise[i];
            end
        end
        n_width = i_op.cap - cur_rise;
        n_fits  = (n_width >= r_accept_min) && (n_width <= r_accept_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_min <= rpwc_pkg::ACCEPT_MIN_RST;
            r_accept_max <= rpwc_pkg::ACCEPT_MAX_RST;
            r_valid_min  <= rpwc_pkg::VALID_MIN_RST;
            r_valid_max  <= rpwc_pkg::VALID_MAX_RST;
            r_timeout    <= rpwc_pkg::TIMEOUT_RST;
        end else if (i_cfg_wr_en) begin
            case (rpwc_pkg::t_cfg_reg'(i_cfg_index))
                rpwc_pkg::CFG_ACCEPT_MIN: r_accept_min <= i_cfg_wr_data;
                rpwc_pkg::CFG_ACCEPT_MAX: r_accept_max <= i_cfg_wr_data;
                rpwc_pkg::CFG_VALID_MIN:  r_valid_min  <= i_cfg_wr_data;
                rpwc_pkg::CFG_VALID_MAX:  r_valid_max  <= i_cfg_wr_data;
                rpwc_pkg::CFG_TIMEOUT:    r_timeout    <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_rise[i]  <= '0;
                r_width[i] <= '0;
                r_stamp[i] <= '0;
            end
            r_now  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= o_op_take;
            if (o_op_take && i_op.is_tick) begin
                r_now <= r_now + SW'(1);
            end
            // Only a channel below CHANNELS can match, so out-of-range edges fall through.
            for (int i = 0; i < CHANNELS; i++) begin
                if (o_op_take && !i_op.is_tick && (i_op.chan == NW'(i))) begin
                    if (i_op.rising) begin
                        r_rise[i] <= i_op.cap;
                    end else if (n_fits) begin
                        r_width[i] <= n_width;
                        r_stamp[i] <= r_now;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_take) begin
            r_pend_chan  <= i_op.chan;
            r_pend_range <= i_op.in_range;
        end
    end

    // The report is built in the cycle after the transaction is taken, from the updated state.
    always_comb begin
        sel_width = '0;
        sel_ok    = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            ok[i] = (r_width[i] >= r_valid_min) && (r_width[i] <= r_valid_max)
                    && ((r_now - r_stamp[i]) <= {{(SW-DW){1'b0}}, r_timeout});
            if (r_pend_chan == NW'(i)) begin
                sel_width = r_width[i];
                sel_ok    = ok[i];
            end
        end
        o_rep.chan       = r_pend_chan;
        o_rep.width_us   = r_pend_range ? sel_width : '0;
        o_rep.chan_valid = r_pend_range && sel_ok;
        o_rep.all_valid  = &ok;
    end

    assign o_rep_valid = r_pend;

`ifndef NO_ASSERTIONS
    a_room_for_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rep_valid |-> !i_out_full)
        else $error("report written into a full result queue");

    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op_take && i_op.is_tick) |=> (r_now == $past(r_now) + SW'(1)))
        else $error("millisecond count did not advance on a tick");

    a_edge_keeps_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op_take && !i_op.is_tick) |=> $stable(r_now))
        else $error("millisecond count moved on an edge transaction");

    a_range_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rep_valid && !r_pend_range) |-> (!o_rep.chan_valid && (o_rep.width_us == '0)))
        else $error("out-of-range channel reported a width or validity");
`endif

endmodule

// ----- hdl/rc_pulse_width_capture.sv -----
// Channel   Direction  Handshake                 Payload
// input     in         push / full               i_req_type, i_channel, i_pin_level,
//                                                i_capture_count
// result    out        empty / pop               o_report_channel, o_width_us,
//                                                o_channel_valid, o_all_valid
// config    in         i_cfg_wr_en               i_cfg_index, i_cfg_wr_data
//
// One transaction is accepted per cycle while full is low; its result passes the input queue,
// the state update and the result queue to reach the result ports, and pops when pop is high.
// Without result stalls, the back-end state update sets the sustained rate of one per cycle.
// Reset is synchronous and active low; it clears both queues, all channel state and the
// millisecond count, and loads the register reset values.
// Stalls on the result side fill the result queue, then the input queue, then raise full.
module rc_pulse_width_capture #(
    parameter int CHANNELS = rpwc_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_req_type,
    input  logic [rpwc_pkg::CHAN_W-1:0] i_channel,
    input  logic                        i_pin_level,
    input  logic [rpwc_pkg::DATA_W-1:0] i_capture_count,
    output logic                        empty,
    input  logic                        pop,
    output logic [rpwc_pkg::CHAN_W-1:0] o_report_channel,
    output logic [rpwc_pkg::DATA_W-1:0] o_width_us,
    output logic                        o_channel_valid,
    output logic                        o_all_valid,
    input  logic                        i_cfg_wr_en,
    input  logic [2:0]                  i_cfg_index,
    input  logic [rpwc_pkg::DATA_W-1:0] i_cfg_wr_data
);

    localparam int CW = $clog2(rpwc_pkg::OUT_DEPTH+1);

    logic              op_valid;
    rpwc_pkg::t_op     op;
    logic              op_take;
    logic [CW-1:0]     out_count;
    logic              out_full;
    logic              rep_valid;
    rpwc_pkg::t_report rep;
    rpwc_pkg::t_report head;

    rpwc_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_req_type      (i_req_type),
        .i_channel       (i_channel),
        .i_pin_level     (i_pin_level),
        .i_capture_count (i_capture_count),
        .o_op_valid      (op_valid),
        .o_op            (op),
        .i_op_take       (op_take)
    );

    rpwc_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op_valid    (op_valid),
        .i_op          (op),
        .o_op_take     (op_take),
        .i_out_count   (out_count),
        .i_out_full    (out_full),
        .o_rep_valid   (rep_valid),
        .o_rep         (rep)
    );

    rpwc_fifo #(
        .WIDTH ($bits(rpwc_pkg::t_report)),
        .DEPTH (rpwc_pkg::OUT_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rep_valid),
        .i_data  (rep),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head),
        .o_count (out_count)
    );

    assign o_report_channel = head.chan;
    assign o_width_us       = head.width_us;
    assign o_channel_valid  = head.chan_valid;
    assign o_all_valid      = head.all_valid;

endmodule
